// ===== sv/lpcp_pkg.sv =====
package lpcp_pkg;

    localparam int DIR_FRAC_BITS = 16;

    localparam int W_POS = 32;
    localparam int W_DIR = 18;
    localparam int W_LIM = 16;

    // Base difference, cosine partial products, cosine.
    localparam int W_DIF = W_POS + 1;
    localparam int W_CP  = 2 * W_DIR;
    localparam int W_C   = W_CP + 2;
    // Projections A and B and their per-axis products.
    localparam int W_DM  = W_DIF + W_DIR;
    localparam int W_AQ  = W_DM + 2;
    // n = c*c - 1, the products c*A and c*B, and the pre-shift numerators.
    localparam int W_N   = 74;
    localparam int W_CA  = 89;
    // Divider operands: numerator magnitude and divisor magnitude.
    localparam int W_NUM = W_CA - 1 + DIR_FRAC_BITS;
    localparam int W_DEN = W_N - 1;
    // Quotient bits below the 64-bit saturation point.
    localparam int Q_BITS  = 63;
    localparam int DIV_LAT = Q_BITS + 2;

    typedef struct packed {
        logic [2:0][W_POS-1:0] ba;
        logic [2:0][W_POS-1:0] bb;
        logic [2:0][W_DIR-1:0] ma;
        logic [2:0][W_DIR-1:0] mb;
    } t_geo;

    typedef struct packed {
        logic [2:0][W_POS-1:0] pa;
        logic [2:0][W_POS-1:0] pb;
        logic                  par;
    } t_res;

endpackage

// ===== sv/lpcp_div.sv =====
module lpcp_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [lpcp_pkg::W_NUM-1:0]    i_num,
    input  logic [lpcp_pkg::W_DEN-1:0]    i_den,
    input  logic                          i_neg,
    input  logic                          i_zero,
    output logic signed [63:0]            o_quot
);
    import lpcp_pkg::*;

    // Fully pipelined restoring divider, one quotient bit per stage. The
    // quotient saturates when the upper numerator bits already reach the divisor.

    logic [W_DEN-1:0]  r_rem  [0:Q_BITS];
    logic [Q_BITS-1:0] r_x    [0:Q_BITS];
    logic [W_DEN-1:0]  r_den  [0:Q_BITS];
    logic              r_neg  [0:Q_BITS];
    logic              r_zero [0:Q_BITS];
    logic              r_ovf  [0:Q_BITS];
    logic [W_DEN-1:0]  n_rem  [0:Q_BITS-1];
    logic [Q_BITS-1:0] n_x    [0:Q_BITS-1];
    logic signed [63:0] r_quot;
    logic [W_DEN-1:0]  w_hi;
    logic [63:0]       w_q;

    assign w_hi = W_DEN'(i_num[W_NUM-1:Q_BITS]);
    assign w_q  = {1'b0, r_x[Q_BITS]};

    always_comb begin
        logic [W_DEN:0] trial;
        logic [W_DEN:0] diff;
        for (int k = 0; k < Q_BITS; k++) begin
            trial = {r_rem[k], r_x[k][Q_BITS-1]};
            diff  = trial - {1'b0, r_den[k]};
            if (trial >= {1'b0, r_den[k]}) begin
                n_rem[k] = diff[W_DEN-1:0];
                n_x[k]   = {r_x[k][Q_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[W_DEN-1:0];
                n_x[k]   = {r_x[k][Q_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_hi;
            r_x[0]    <= i_num[Q_BITS-1:0];
            r_den[0]  <= i_den;
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_zero;
            r_ovf[0]  <= (w_hi >= i_den);
            for (int k = 0; k < Q_BITS; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_x[k+1]    <= n_x[k];
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
            priority if (r_zero[Q_BITS]) begin
                r_quot <= '0;
            end else if (r_ovf[Q_BITS]) begin
                r_quot <= r_neg[Q_BITS] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                r_quot <= r_neg[Q_BITS] ? $signed(-w_q) : $signed(w_q);
            end
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== sv/line_pair_closest_points_core.sv =====
// Closest points between two 3D lines. Each transaction on the input channel
// carries two lines (Q16.16 base point, Q2.16 direction); each output
// transaction returns the closest point on each line, saturated to Q16.16,
// and a flag that is set when |c*c - 1| is at or below parallel_limit * 2^-32
// (then the point on line A is its base and line B uses t = A / c). The block
// takes one transaction per cycle while o_in_ready is high, that is while the
// skid register is empty. The transaction passes 76 registers, the first of
// them loading at the edge that accepts the input transaction:
// 7 stages of dot products and numerator setup, 65 stages of the pipelined
// one-bit-per-stage divider that sets the depth, 3 stages that scale the
// directions and add the bases, and the output register. A skid register
// behind the output catches the result in flight when the consumer stalls,
// so the pipeline stops only once it is full. The configuration port is always
// ready; write it only while no transaction is in flight.
module line_pair_closest_points_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lpcp_pkg::W_LIM-1:0]    i_cfg_parallel_limit,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_base_a_x,
    input  logic signed [31:0]            i_base_a_y,
    input  logic signed [31:0]            i_base_a_z,
    input  logic signed [17:0]            i_dir_a_x,
    input  logic signed [17:0]            i_dir_a_y,
    input  logic signed [17:0]            i_dir_a_z,
    input  logic signed [31:0]            i_base_b_x,
    input  logic signed [31:0]            i_base_b_y,
    input  logic signed [31:0]            i_base_b_z,
    input  logic signed [17:0]            i_dir_b_x,
    input  logic signed [17:0]            i_dir_b_y,
    input  logic signed [17:0]            i_dir_b_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_near_a_x,
    output logic signed [31:0]            o_near_a_y,
    output logic signed [31:0]            o_near_a_z,
    output logic signed [31:0]            o_near_b_x,
    output logic signed [31:0]            o_near_b_y,
    output logic signed [31:0]            o_near_b_z,
    output logic                          o_parallel_flag
);
    import lpcp_pkg::*;

    // Split points for the wide multiplies: c is cut at C_LO, A and B at AQ_LO,
    // the path parameters at T_LO.
    localparam int C_LO  = 19;
    localparam int AQ_LO = 26;
    localparam int T_LO  = 32;
    localparam int W_CH  = W_C - C_LO;
    localparam int W_AH  = W_AQ - AQ_LO;
    localparam int W_S   = 82;
    localparam int W_P   = W_S - DIR_FRAC_BITS + 1;

    logic [W_LIM-1:0] r_limit;
    logic             w_en;
    t_geo             w_geo;

    // Output register with a one-entry skid behind it.
    logic r_ov, r_sv;
    t_res r_out, r_skid;

    // Pipeline enable: the whole datapath advances unless the skid is full.
    assign w_en        = !r_sv;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= W_LIM'(1);
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_parallel_limit;
        end
    end

    assign w_geo.ba = {i_base_a_z, i_base_a_y, i_base_a_x};
    assign w_geo.bb = {i_base_b_z, i_base_b_y, i_base_b_x};
    assign w_geo.ma = {i_dir_a_z, i_dir_a_y, i_dir_a_x};
    assign w_geo.mb = {i_dir_b_z, i_dir_b_y, i_dir_b_x};

    // Stage registers.
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    t_geo r1_g, r2_g, r3_g, r4_g, r5_g, r6_g, r7_g;

    logic signed [W_DIF-1:0] r1_d  [0:2];
    logic signed [W_CP-1:0]  r1_cp [0:2];
    logic signed [W_C-1:0]   r2_c;
    logic signed [W_DM-1:0]  r2_dma [0:2];
    logic signed [W_DM-1:0]  r2_dmb [0:2];
    logic signed [W_C-1:0]   r3_c;
    logic signed [W_AQ-1:0]  r3_aq, r3_bq;
    logic signed [2*W_CH-1:0] r3_hh;
    logic signed [2*W_CH:0]  r3_hl;
    logic [2*C_LO-1:0]       r3_ll;
    logic signed [W_C-1:0]   r4_c;
    logic signed [W_AQ-1:0]  r4_aq, r4_bq;
    logic signed [W_N-1:0]   r4_n;
    logic signed [W_CH+W_AH-1:0] r4_ahh, r4_bhh;
    logic signed [W_CH+AQ_LO:0]  r4_ahl, r4_bhl;
    logic signed [C_LO+W_AH:0]   r4_alh, r4_blh;
    logic [C_LO+AQ_LO-1:0]       r4_all, r4_bll;
    logic signed [W_C-1:0]   r5_c;
    logic signed [W_AQ-1:0]  r5_aq, r5_bq;
    logic signed [W_N-1:0]   r5_n;
    logic signed [W_CA-1:0]  r5_ca, r5_cb;
    logic                    r5_par;
    logic signed [W_CA-1:0]  r6_na, r6_nb;
    logic signed [W_N-1:0]   r6_den;
    logic                    r6_par;
    logic [W_NUM-1:0]        r7_num_a, r7_num_b;
    logic [W_DEN-1:0]        r7_den;
    logic                    r7_neg_a, r7_neg_b, r7_zero_a, r7_zero_b, r7_par;

    logic r_dv   [0:DIV_LAT-1];
    logic r_dpar [0:DIV_LAT-1];
    t_geo r_dg   [0:DIV_LAT-1];

    logic signed [63:0] w_ta, w_tb;

    logic r_m1_v, r_m2_v, r_m3_v;
    logic r_m1_par, r_m2_par;
    t_geo r_m1_g, r_m2_g;
    logic signed [T_LO+W_DIR-1:0] r_m1_ah [0:2];
    logic signed [T_LO+W_DIR:0]   r_m1_al [0:2];
    logic signed [T_LO+W_DIR-1:0] r_m1_bh [0:2];
    logic signed [T_LO+W_DIR:0]   r_m1_bl [0:2];
    logic signed [W_S-1:0]        r_m2_sa [0:2];
    logic signed [W_S-1:0]        r_m2_sb [0:2];
    t_res r_m3;

    // Combinational next values.
    logic signed [W_DIF-1:0] n1_d  [0:2];
    logic signed [W_CP-1:0]  n1_cp [0:2];
    logic signed [W_C-1:0]   n2_c;
    logic signed [W_DM-1:0]  n2_dma [0:2];
    logic signed [W_DM-1:0]  n2_dmb [0:2];
    logic signed [W_AQ-1:0]  n3_aq, n3_bq;
    logic signed [2*W_CH-1:0] n3_hh;
    logic signed [2*W_CH:0]  n3_hl;
    logic [2*C_LO-1:0]       n3_ll;
    logic signed [W_N-1:0]   n4_n;
    logic signed [W_CH+W_AH-1:0] n4_ahh, n4_bhh;
    logic signed [W_CH+AQ_LO:0]  n4_ahl, n4_bhl;
    logic signed [C_LO+W_AH:0]   n4_alh, n4_blh;
    logic [C_LO+AQ_LO-1:0]       n4_all, n4_bll;
    logic signed [W_CA-1:0]  n5_ca, n5_cb;
    logic                    n5_par;
    logic signed [W_CA-1:0]  n6_na, n6_nb;
    logic signed [W_N-1:0]   n6_den;
    logic [W_NUM-1:0]        n7_num_a, n7_num_b;
    logic [W_DEN-1:0]        n7_den;
    logic signed [T_LO+W_DIR-1:0] n_m1_ah [0:2];
    logic signed [T_LO+W_DIR:0]   n_m1_al [0:2];
    logic signed [T_LO+W_DIR-1:0] n_m1_bh [0:2];
    logic signed [T_LO+W_DIR:0]   n_m1_bl [0:2];
    logic signed [W_S-1:0]        n_m2_sa [0:2];
    logic signed [W_S-1:0]        n_m2_sb [0:2];
    t_res n_m3;

    function automatic logic [W_POS-1:0] sat_pos(input logic signed [W_P-1:0] p);
        logic [W_P-W_POS:0] top;
        top = p[W_P-1:W_POS-1];
        if (top == '0 || top == '1) begin
            sat_pos = p[W_POS-1:0];
        end else if (p[W_P-1]) begin
            sat_pos = {1'b1, {(W_POS-1){1'b0}}};
        end else begin
            sat_pos = {1'b0, {(W_POS-1){1'b1}}};
        end
    endfunction

    always_comb begin
        logic signed [W_CH-1:0]  ch;
        logic signed [C_LO:0]    cl;
        logic signed [W_AH-1:0]  ah, bh;
        logic signed [AQ_LO:0]   al, bl;
        logic [W_N-1:0]          absn;
        logic [W_CA-1:0]         mag_a, mag_b;
        logic [W_N-1:0]          mag_d;

        // Stage 1: base difference and cosine partial products.
        for (int i = 0; i < 3; i++) begin
            n1_d[i]  = $signed({w_geo.ba[i][W_POS-1], w_geo.ba[i]})
                     - $signed({w_geo.bb[i][W_POS-1], w_geo.bb[i]});
            n1_cp[i] = $signed(w_geo.ma[i]) * $signed(w_geo.mb[i]);
        end

        // Stage 2: cosine and projection partial products.
        n2_c = W_C'(r1_cp[0]) + W_C'(r1_cp[1]) + W_C'(r1_cp[2]);
        for (int i = 0; i < 3; i++) begin
            n2_dma[i] = r1_d[i] * $signed(r1_g.ma[i]);
            n2_dmb[i] = r1_d[i] * $signed(r1_g.mb[i]);
        end

        // Stage 3: A and B, and the pieces of c*c.
        n3_aq = W_AQ'(r2_dma[0]) + W_AQ'(r2_dma[1]) + W_AQ'(r2_dma[2]);
        n3_bq = W_AQ'(r2_dmb[0]) + W_AQ'(r2_dmb[1]) + W_AQ'(r2_dmb[2]);
        ch    = $signed(r2_c[W_C-1:C_LO]);
        cl    = $signed({1'b0, r2_c[C_LO-1:0]});
        n3_hh = ch * ch;
        n3_hl = ch * cl;
        n3_ll = r2_c[C_LO-1:0] * r2_c[C_LO-1:0];

        // Stage 4: n = c*c - 1, and the pieces of c*A and c*B.
        n4_n = (W_N'(r3_hh) <<< (2 * C_LO)) + (W_N'(r3_hl) <<< (C_LO + 1))
             + $signed(W_N'(r3_ll)) - (W_N'(1) <<< (4 * DIR_FRAC_BITS));
        ch = $signed(r3_c[W_C-1:C_LO]);
        cl = $signed({1'b0, r3_c[C_LO-1:0]});
        ah = $signed(r3_aq[W_AQ-1:AQ_LO]);
        al = $signed({1'b0, r3_aq[AQ_LO-1:0]});
        bh = $signed(r3_bq[W_AQ-1:AQ_LO]);
        bl = $signed({1'b0, r3_bq[AQ_LO-1:0]});
        n4_ahh = ch * ah;
        n4_ahl = ch * al;
        n4_alh = cl * ah;
        n4_all = r3_c[C_LO-1:0] * r3_aq[AQ_LO-1:0];
        n4_bhh = ch * bh;
        n4_bhl = ch * bl;
        n4_blh = cl * bh;
        n4_bll = r3_c[C_LO-1:0] * r3_bq[AQ_LO-1:0];

        // Stage 5: parallel test and the sums for c*A and c*B.
        absn   = r4_n[W_N-1] ? W_N'(-r4_n) : W_N'(r4_n);
        n5_par = (absn <= W_N'({r_limit, 32'd0}));
        n5_ca  = (W_CA'(r4_ahh) <<< (C_LO + AQ_LO)) + (W_CA'(r4_ahl) <<< C_LO)
               + (W_CA'(r4_alh) <<< AQ_LO) + $signed(W_CA'(r4_all));
        n5_cb  = (W_CA'(r4_bhh) <<< (C_LO + AQ_LO)) + (W_CA'(r4_bhl) <<< C_LO)
               + (W_CA'(r4_blh) <<< AQ_LO) + $signed(W_CA'(r4_bll));

        // Stage 6: numerators before the final shift, and the divisor.
        n6_na = (W_CA'(r5_aq) <<< (2 * DIR_FRAC_BITS)) - r5_cb;
        if (r5_par) begin
            n6_nb  = W_CA'(r5_aq);
            n6_den = W_N'(r5_c);
        end else begin
            n6_nb  = r5_ca - (W_CA'(r5_bq) <<< (2 * DIR_FRAC_BITS));
            n6_den = r5_n;
        end

        // Stage 7: sign and magnitude for the divider.
        mag_a    = r6_na[W_CA-1] ? W_CA'(-r6_na) : W_CA'(r6_na);
        mag_b    = r6_nb[W_CA-1] ? W_CA'(-r6_nb) : W_CA'(r6_nb);
        mag_d    = r6_den[W_N-1] ? W_N'(-r6_den) : W_N'(r6_den);
        n7_num_a = {mag_a[W_CA-2:0], {DIR_FRAC_BITS{1'b0}}};
        n7_num_b = {mag_b[W_CA-2:0], {DIR_FRAC_BITS{1'b0}}};
        n7_den   = mag_d[W_DEN-1:0];

        // After the divider: t times direction in two halves.
        for (int i = 0; i < 3; i++) begin
            n_m1_ah[i] = $signed(w_ta[63:T_LO]) * $signed(r_dg[DIV_LAT-1].ma[i]);
            n_m1_al[i] = $signed({1'b0, w_ta[T_LO-1:0]}) * $signed(r_dg[DIV_LAT-1].ma[i]);
            n_m1_bh[i] = $signed(w_tb[63:T_LO]) * $signed(r_dg[DIV_LAT-1].mb[i]);
            n_m1_bl[i] = $signed({1'b0, w_tb[T_LO-1:0]}) * $signed(r_dg[DIV_LAT-1].mb[i]);
            n_m2_sa[i] = (W_S'(r_m1_ah[i]) <<< T_LO) + W_S'(r_m1_al[i]);
            n_m2_sb[i] = (W_S'(r_m1_bh[i]) <<< T_LO) + W_S'(r_m1_bl[i]);
            n_m3.pa[i] = sat_pos(W_P'($signed(r_m2_g.ba[i]))
                                 + W_P'(r_m2_sa[i] >>> DIR_FRAC_BITS));
            n_m3.pb[i] = sat_pos(W_P'($signed(r_m2_g.bb[i]))
                                 + W_P'(r_m2_sb[i] >>> DIR_FRAC_BITS));
        end
        n_m3.par = r_m2_par;
    end

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_m1_v <= 1'b0; r_m2_v <= 1'b0; r_m3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v;
            r_dv[0] <= r7_v;
            for (int k = 0; k < DIV_LAT - 1; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_m1_v <= r_dv[DIV_LAT-1];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_g <= w_geo;  r1_d <= n1_d;  r1_cp <= n1_cp;
            r2_g <= r1_g;   r2_c <= n2_c;  r2_dma <= n2_dma;  r2_dmb <= n2_dmb;
            r3_g <= r2_g;   r3_c <= r2_c;  r3_aq <= n3_aq;    r3_bq <= n3_bq;
            r3_hh <= n3_hh; r3_hl <= n3_hl; r3_ll <= n3_ll;
            r4_g <= r3_g;   r4_c <= r3_c;  r4_aq <= r3_aq;    r4_bq <= r3_bq;
            r4_n <= n4_n;
            r4_ahh <= n4_ahh; r4_ahl <= n4_ahl; r4_alh <= n4_alh; r4_all <= n4_all;
            r4_bhh <= n4_bhh; r4_bhl <= n4_bhl; r4_blh <= n4_blh; r4_bll <= n4_bll;
            r5_g <= r4_g;   r5_c <= r4_c;  r5_aq <= r4_aq;    r5_bq <= r4_bq;
            r5_n <= r4_n;   r5_ca <= n5_ca; r5_cb <= n5_cb;   r5_par <= n5_par;
            r6_g <= r5_g;   r6_na <= n6_na; r6_nb <= n6_nb;   r6_den <= n6_den;
            r6_par <= r5_par;
            r7_g <= r6_g;   r7_num_a <= n7_num_a; r7_num_b <= n7_num_b;
            r7_den <= n7_den;
            r7_neg_a  <= r6_na[W_CA-1] ^ r6_den[W_N-1];
            r7_neg_b  <= r6_nb[W_CA-1] ^ r6_den[W_N-1];
            r7_zero_a <= r6_par || (r6_den == '0);
            r7_zero_b <= (r6_den == '0);
            r7_par    <= r6_par;
            r_dg[0]   <= r7_g;
            r_dpar[0] <= r7_par;
            for (int k = 0; k < DIV_LAT - 1; k++) begin
                r_dg[k+1]   <= r_dg[k];
                r_dpar[k+1] <= r_dpar[k];
            end
            r_m1_g   <= r_dg[DIV_LAT-1];
            r_m1_par <= r_dpar[DIV_LAT-1];
            r_m1_ah <= n_m1_ah; r_m1_al <= n_m1_al;
            r_m1_bh <= n_m1_bh; r_m1_bl <= n_m1_bl;
            r_m2_g   <= r_m1_g;
            r_m2_par <= r_m1_par;
            r_m2_sa <= n_m2_sa; r_m2_sb <= n_m2_sb;
            r_m3 <= n_m3;
        end
    end

    // The two path parameters: ta is forced to zero on the parallel branch.
    lpcp_div u_div_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r7_num_a),
        .i_den  (r7_den),
        .i_neg  (r7_neg_a),
        .i_zero (r7_zero_a),
        .o_quot (w_ta)
    );

    lpcp_div u_div_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r7_num_b),
        .i_den  (r7_den),
        .i_neg  (r7_neg_b),
        .i_zero (r7_zero_b),
        .o_quot (w_tb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_out_ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_m3_v;
            end
        end else if (r_m3_v && !r_sv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_out_ready) begin
            r_out <= r_sv ? r_skid : r_m3;
        end else if (!r_sv) begin
            r_skid <= r_m3;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_near_a_x      = $signed(r_out.pa[0]);
    assign o_near_a_y      = $signed(r_out.pa[1]);
    assign o_near_a_z      = $signed(r_out.pa[2]);
    assign o_near_b_x      = $signed(r_out.pb[0]);
    assign o_near_b_y      = $signed(r_out.pb[1]);
    assign o_near_b_z      = $signed(r_out.pb[2]);
    assign o_parallel_flag = r_out.par;

    // A held result in the skid implies the output register is also full.
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a result while the output register is empty");

    // A stalled consumer keeps the skid occupied.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_out_ready) |=> r_sv)
        else $error("skid result dropped during a stall");

    // On the parallel branch the point on line A is its own base.
    a_par_ta_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[DIV_LAT-1] && r_dpar[DIV_LAT-1]) |-> (w_ta == '0))
        else $error("nonzero ta on the parallel branch");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the closest-points pipeline. A queue of line pairs
// is built up front; a clocked driver presents them with random gaps, a
// clocked monitor accepts results with random stalls and checks every field
// against the prediction made when the input transaction was accepted.
module testbench;

    // One line pair as presented to the block.
    typedef struct {
        logic signed [31:0] ba [3];
        logic signed [17:0] ma [3];
        logic signed [31:0] bb [3];
        logic signed [17:0] mb [3];
    } line_pair_t;

    // One predicted result transaction.
    typedef struct {
        logic signed [31:0] pa [3];
        logic signed [31:0] pb [3];
        logic               par;
    } near_points_t;

    // Items with set_limit switch the limit register; a setting applies to all
    // items that follow it until the next one.
    typedef struct {
        line_pair_t pair;
        bit         set_limit;
        logic [15:0] limit;
    } pending_t;

    localparam int DRAIN_CYCLES = 120;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [lpcp_pkg::W_LIM-1:0] i_cfg_parallel_limit;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [31:0] i_base_a_x, i_base_a_y, i_base_a_z;
    logic signed [17:0] i_dir_a_x, i_dir_a_y, i_dir_a_z;
    logic signed [31:0] i_base_b_x, i_base_b_y, i_base_b_z;
    logic signed [17:0] i_dir_b_x, i_dir_b_y, i_dir_b_z;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [31:0] o_near_a_x, o_near_a_y, o_near_a_z;
    logic signed [31:0] o_near_b_x, o_near_b_y, o_near_b_z;
    logic o_parallel_flag;

    line_pair_closest_points_core DUT (.*);

    pending_t     pending_q[$];
    near_points_t expected_q[$];
    logic [15:0]  limit_model;
    int           errors;
    int           results_seen;
    int           parallel_seen;
    bit           stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a wide signed value to a narrower signed range.
    function automatic logic signed [127:0] clamp_wide(logic signed [127:0] v, int bits);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
        lo = -(128'sd1 <<< (bits - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Signed division truncating toward zero; a zero divisor gives zero.
    function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        if (d == 0) return 0;
        return n / d;
    endfunction

    // Exact fixed-point prediction of the closest points for one pair.
    function automatic near_points_t predict_near_points(line_pair_t p, logic [15:0] lim);
        near_points_t r;
        logic signed [127:0] ma [3], mb [3], dv [3];
        logic signed [127:0] c, aq, bq, n, absn, thr, ta, tb, pa, pb;
        aq = 0;
        bq = 0;
        c = 0;
        for (int i = 0; i < 3; i++) begin
            ma[i] = p.ma[i];
            mb[i] = p.mb[i];
            dv[i] = 128'(p.ba[i]) - 128'(p.bb[i]);
            c += ma[i] * mb[i];
            aq += dv[i] * ma[i];
            bq += dv[i] * mb[i];
        end
        n = c * c - (128'sd1 <<< 64);
        absn = (n < 0) ? -n : n;
        thr = 128'(lim) <<< 32;
        r.par = (absn <= thr);
        if (r.par) begin
            ta = 0;
            tb = div_trunc(aq <<< 16, c);
        end else begin
            ta = div_trunc(((aq <<< 32) - c * bq) <<< 16, n);
            tb = div_trunc((c * aq - (bq <<< 32)) <<< 16, n);
        end
        ta = clamp_wide(ta, 64);
        tb = clamp_wide(tb, 64);
        for (int i = 0; i < 3; i++) begin
            pa = 128'(p.ba[i]) + ((ta * ma[i]) >>> 16);
            pb = 128'(p.bb[i]) + ((tb * mb[i]) >>> 16);
            r.pa[i] = 32'(clamp_wide(pa, 32));
            r.pb[i] = 32'(clamp_wide(pb, 32));
        end
        return r;
    endfunction

    function automatic logic signed [17:0] rand_dir();
        case ($urandom_range(0, 9))
            0: return 18'sh1ffff;
            1: return -18'sh20000;
            2: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    // Random pair; a share of them is nearly or exactly parallel so that
    // both branches see a lot of traffic.
    function automatic line_pair_t rand_pair();
        line_pair_t p;
        int kind;
        kind = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++) begin
            p.ba[i] = rand_pos();
            p.bb[i] = rand_pos();
            p.ma[i] = rand_dir();
            p.mb[i] = (kind == 0) ? p.ma[i] + 18'($signed($urandom_range(0, 2)) - 1)
                    : (kind == 1) ? -p.ma[i] : rand_dir();
        end
        if (kind == 2) begin
            // Unit axis directions give c*c - 1 exactly at zero or at minus one.
            p.ma = '{18'sh10000, 0, 0};
            p.mb = '{($urandom_range(0, 1) ? 18'sh10000 : 18'sh0), 0, 18'sh10000};
        end
        return p;
    endfunction

    task automatic push_pair(line_pair_t p, bit set, logic [15:0] lim);
        pending_t e;
        e.pair = p;
        e.set_limit = set;
        e.limit = lim;
        pending_q.push_back(e);
    endtask

    // Build the stimulus: directed corners first, then the random body.
    initial begin
        line_pair_t p;
        for (int i = 0; i < 3; i++) begin
            p.ba[i] = 0; p.bb[i] = 0; p.ma[i] = 0; p.mb[i] = 0;
        end
        push_pair(p, 0, 0);                       // all zero, zero cosine
        p.ma = '{18'sh10000, 0, 0};
        p.mb = '{18'sh10000, 0, 0};
        p.ba = '{0, 32'sh00010000, 0};
        push_pair(p, 0, 0);                       // exact parallel
        p.mb = '{0, 18'sh10000, 0};
        p.bb = '{32'sh00030000, 0, 32'sh00050000};
        push_pair(p, 0, 0);                       // perpendicular lines
        p.ba = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        p.bb = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        p.ma = '{18'sh1ffff, 18'sh1ffff, 18'sh1ffff};
        p.mb = '{-18'sh20000, -18'sh20000, -18'sh20000};
        push_pair(p, 1, 16'hffff);                // extreme fields, saturation
        p.mb = '{18'sh1ffff, 18'sh1ffff, 18'sh1fffe};
        push_pair(p, 0, 0);
        p.ma = '{18'sh10000, 0, 0};
        p.mb = '{18'sh10000, 18'sh00001, 0};
        push_pair(p, 1, 16'h0000);                // near parallel, zero limit
        push_pair(p, 1, 16'h0001);
        push_pair(p, 1, 16'h8000);
        p.mb = '{-18'sh10000, 0, 0};
        push_pair(p, 0, 0);                       // anti-parallel
        for (int k = 0; k < 12; k++) push_pair(rand_pair(), 0, 0);
        for (int k = 0; k < 2000; k++) begin
            push_pair(rand_pair(), (k % 400 == 399), 16'($urandom));
        end
        stim_done = 1'b1;
    end

    // Driver: waits its drawn gap, applies a pending limit change only once the
    // pipeline is empty, then holds valid until the transaction is accepted.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_parallel_limit = '0;
        i_in_valid = 1'b0;
        {i_base_a_x, i_base_a_y, i_base_a_z, i_base_b_x, i_base_b_y, i_base_b_z} = '0;
        {i_dir_a_x, i_dir_a_y, i_dir_a_z, i_dir_b_x, i_dir_b_y, i_dir_b_z} = '0;
        i_out_ready = 1'b0;
        limit_model = 16'd1;
        errors = 0;
        results_seen = 0;
        parallel_seen = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    int  gap_left;
    int  sent;
    bit  busy;
    pending_t cur;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_left <= $urandom_range(0, 5);
            busy <= 1'b0;
            sent <= 0;
        end else if (i_cfg_valid) begin
            // Configuration write completes at this edge.
            if (o_cfg_ready) i_cfg_valid <= 1'b0;
        end else if (busy) begin
            if (o_in_ready) begin
                expected_q.push_back(predict_near_points(cur.pair, limit_model));
                i_in_valid <= 1'b0;
                busy <= 1'b0;
                sent <= sent + 1;
                gap_left <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            end
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
            if (pending_q[0].set_limit || sent == 1000) begin
                // Hold off until every result is back, then let the tail drain.
                if (expected_q.size() == 0) begin
                    if (pending_q[0].set_limit) begin
                        i_cfg_valid <= 1'b1;
                        i_cfg_parallel_limit <= pending_q[0].limit;
                        limit_model <= pending_q[0].limit;
                        pending_q[0].set_limit = 1'b0;
                    end
                    if (sent == 1000) sent <= sent + 1;
                    gap_left <= DRAIN_CYCLES;
                end
            end else begin
                cur = pending_q.pop_front();
                {i_base_a_x, i_base_a_y, i_base_a_z} <= {cur.pair.ba[0], cur.pair.ba[1], cur.pair.ba[2]};
                {i_dir_a_x, i_dir_a_y, i_dir_a_z} <= {cur.pair.ma[0], cur.pair.ma[1], cur.pair.ma[2]};
                {i_base_b_x, i_base_b_y, i_base_b_z} <= {cur.pair.bb[0], cur.pair.bb[1], cur.pair.bb[2]};
                {i_dir_b_x, i_dir_b_y, i_dir_b_z} <= {cur.pair.mb[0], cur.pair.mb[1], cur.pair.mb[2]};
                i_in_valid <= 1'b1;
                busy <= 1'b1;
            end
        end
    end

    // Monitor: random backpressure, then a field-by-field compare of every
    // accepted result transaction against the oldest prediction.
    int stall_left;

    always @(posedge i_clk) begin
        near_points_t exp_r;
        logic signed [31:0] got_pa [3];
        logic signed [31:0] got_pb [3];
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            stall_left <= $urandom_range(0, 5);
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_pa = '{o_near_a_x, o_near_a_y, o_near_a_z};
                got_pb = '{o_near_b_x, o_near_b_y, o_near_b_z};
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with no prediction waiting", $time);
                    bad = bad + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.par) parallel_seen <= parallel_seen + 1;
                    for (int i = 0; i < 3; i++) begin
                        if (got_pa[i] !== exp_r.pa[i]) begin
                            $display("%0t: near_a[%0d] expected %h actual %h",
                                     $time, i, exp_r.pa[i], got_pa[i]);
                            bad = bad + 1;
                        end
                        if (got_pb[i] !== exp_r.pb[i]) begin
                            $display("%0t: near_b[%0d] expected %h actual %h",
                                     $time, i, exp_r.pb[i], got_pb[i]);
                            bad = bad + 1;
                        end
                    end
                    if (o_parallel_flag !== exp_r.par) begin
                        $display("%0t: parallel_flag expected %b actual %b",
                                 $time, exp_r.par, o_parallel_flag);
                        bad = bad + 1;
                    end
                end
                if (bad != 0) errors <= errors + bad;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid) stall_left <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            end
        end
    end

    // End of run: all items sent, all results back, then a short tail.
    initial begin
        wait (stim_done && i_rst_n);
        wait (pending_q.size() == 0 && !busy && !i_cfg_valid && expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d closest-point results, %0d of them on the parallel branch.",
                 results_seen, parallel_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench failed");
        $finish;
    end

endmodule
